// ===== rtl/siphash_keyed_hash_unit_assert.svh =====
// Assertion macros used by the SipHash checker file.
`ifndef SIPHASH_KEYED_HASH_UNIT_ASSERT_SVH
`define SIPHASH_KEYED_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SIP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("siphash assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("siphash assertion failed");

`endif

// ===== rtl/siphash_pkg.sv =====
// Package: SipHash constants, lane type, sequencer states and register indexes.
`timescale 1ns / 1ps
package siphash_pkg;

   localparam int WORD_W     = 64;
   localparam int BYTES_W    = 4;
   localparam int ROUNDS_W   = 4;
   localparam int LEN_W      = 8;
   localparam int CSR_IDX_W  = 3;

   localparam logic [WORD_W-1:0] INIT_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;

   localparam logic [LEN_W-1:0] TWEAK_WIDE   = 8'hee;
   localparam logic [LEN_W-1:0] TWEAK_NARROW = 8'hff;
   localparam logic [LEN_W-1:0] TWEAK_SECOND = 8'hdd;

   localparam logic [BYTES_W-1:0]  FULL_BYTES     = 4'd8;
   localparam logic [ROUNDS_W-1:0] RESET_C_ROUNDS = 4'd2;
   localparam logic [ROUNDS_W-1:0] RESET_D_ROUNDS = 4'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_OUTPUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMP_ROUNDS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_ROUNDS = 3'd4;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } lanes_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_FIN1,
      ST_FIN2
   } seq_state_type;

endpackage

// ===== rtl/siphash_if.sv =====
// Stream interfaces for message beats and digest beats.
`timescale 1ns / 1ps
interface siphash_req_if;
   logic                                valid;
   logic                                ready;
   logic [siphash_pkg::WORD_W-1:0]      message_word;
   logic [siphash_pkg::BYTES_W-1:0]     word_bytes;
   logic                                last_word;

   modport source (output valid, output message_word, output word_bytes,
                   output last_word, input ready);
   modport sink   (input valid, input message_word, input word_bytes,
                   input last_word, output ready);
endinterface

interface siphash_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [siphash_pkg::WORD_W-1:0]      hash_word;
   logic                                final_part;

   modport source (output valid, output hash_word, output final_part, input ready);
   modport sink   (input valid, input hash_word, input final_part, output ready);
endinterface

// ===== rtl/siphash_keyed_hash_unit.sv =====
// Top level: keyed SipHash-c-d engine with one shared SipRound unit.
// Sequence: a non-last word is taken in ST_IDLE, then runs its c compression rounds in ST_COMP.
// A last word of 8 bytes then runs c more rounds on the length block, then d rounds per
// digest phase (one phase narrow, two wide), and each phase may wait on a full digest register.
// Throughput is set by the single SipRound unit: one round per cycle, one word at a time.
// Reset (synchronous, active high) idles the sequencer, drops any digest and restores the CSRs.
`timescale 1ns / 1ps
module siphash_keyed_hash_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   siphash_req_if.sink                            req_stream,
   siphash_rsp_if.source                          rsp_stream,
   input  logic                                   csr_write_enable,
   input  logic [siphash_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [siphash_pkg::WORD_W-1:0]         csr_write_data
);

   // Configuration registers
   logic [63:0] key_low_ff, key_high_ff;
   logic        wide_ff;
   logic [3:0]  comp_rounds_ff, fin_rounds_ff;

   // Sequencer and datapath
   siphash_pkg::seq_state_type state_ff, state_in;
   siphash_pkg::lanes_type     lanes_ff, lanes_in;
   siphash_pkg::lanes_type     round_res, src;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] m_ff, m_in;       // word absorbed now; XOR into lane a at the end
   logic [63:0] blk_ff, blk_in;   // final block still owed after a full last word
   logic        need_blk_ff, need_blk_in;
   logic        last_ff, last_in;
   logic        in_msg_ff, in_msg_in;
   logic [7:0]  len_ff, len_in;

   // Digest output register
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_hash_ff, out_hash_in;
   logic        out_final_ff, out_final_in;

   logic        accept, out_free, finishing;
   logic [3:0]  nb_sat, len_add;
   logic [7:0]  len_base, len_new;
   logic [63:0] tail_mask, tail, block, m_first;
   logic        full_word;
   siphash_pkg::lanes_type start;

   assign accept   = req_stream.valid && req_stream.ready;
   assign out_free = !out_valid_ff || rsp_stream.ready;

   siphash_round u_round (
      .round_src (lanes_ff),
      .round_res (round_res)
   );

   // The last round of a phase folds into the closing step; with a count of
   // zero the closing step works on the lanes as they stand.
   assign finishing = (cnt_ff <= 4'd1);
   assign src       = (cnt_ff == 4'd0) ? lanes_ff : round_res;

   // Accept-side preparation: lane init, length, final block
   always_comb begin
      start.a = siphash_pkg::INIT_C0 ^ key_low_ff;
      start.b = siphash_pkg::INIT_C1 ^ key_high_ff;
      start.c = siphash_pkg::INIT_C2 ^ key_low_ff;
      start.d = siphash_pkg::INIT_C3 ^ key_high_ff;
      if (wide_ff) begin
         start.b = start.b ^ {56'd0, siphash_pkg::TWEAK_WIDE};
      end
      if (in_msg_ff) begin
         start = lanes_ff;
      end
      nb_sat    = (req_stream.word_bytes > siphash_pkg::FULL_BYTES) ?
                  siphash_pkg::FULL_BYTES : req_stream.word_bytes;
      len_add   = req_stream.last_word ? nb_sat : siphash_pkg::FULL_BYTES;
      len_base  = in_msg_ff ? len_ff : 8'd0;
      len_new   = len_base + {4'd0, len_add};
      full_word = !req_stream.last_word || (nb_sat == siphash_pkg::FULL_BYTES);
      tail_mask = (64'd1 << {nb_sat[2:0], 3'b000}) - 64'd1;
      tail      = (nb_sat == siphash_pkg::FULL_BYTES) ? 64'd0 :
                  (req_stream.message_word & tail_mask);
      block     = tail | {len_new, 56'd0};
      m_first   = full_word ? req_stream.message_word : block;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         siphash_pkg::ST_IDLE: begin
            if (accept) state_in = siphash_pkg::ST_COMP;
         end
         siphash_pkg::ST_COMP: begin
            if (finishing && !need_blk_ff) begin
               state_in = last_ff ? siphash_pkg::ST_FIN1 : siphash_pkg::ST_IDLE;
            end
         end
         siphash_pkg::ST_FIN1: begin
            if (finishing && out_free) begin
               state_in = wide_ff ? siphash_pkg::ST_FIN2 : siphash_pkg::ST_IDLE;
            end
         end
         siphash_pkg::ST_FIN2: begin
            if (finishing && out_free) state_in = siphash_pkg::ST_IDLE;
         end
         default: state_in = siphash_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates
   always_comb begin
      lanes_in     = lanes_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      blk_in       = blk_ff;
      need_blk_in  = need_blk_ff;
      last_in      = last_ff;
      in_msg_in    = in_msg_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && !rsp_stream.ready;
      out_hash_in  = out_hash_ff;
      out_final_in = out_final_ff;
      unique case (state_ff)
         siphash_pkg::ST_IDLE: begin
            if (accept) begin
               lanes_in     = start;
               lanes_in.d   = start.d ^ m_first;
               m_in         = m_first;
               blk_in       = block;
               need_blk_in  = req_stream.last_word && (nb_sat == siphash_pkg::FULL_BYTES);
               last_in      = req_stream.last_word;
               in_msg_in    = !req_stream.last_word;
               len_in       = len_new;
               cnt_in       = comp_rounds_ff;
            end
         end
         siphash_pkg::ST_COMP: begin
            if (!finishing) begin
               lanes_in = round_res;
               cnt_in   = cnt_ff - 4'd1;
            end else begin
               lanes_in   = src;
               lanes_in.a = src.a ^ m_ff;
               if (need_blk_ff) begin
                  // Full last word absorbed; now absorb the length block
                  lanes_in.d  = src.d ^ blk_ff;
                  m_in        = blk_ff;
                  need_blk_in = 1'b0;
                  cnt_in      = comp_rounds_ff;
               end else if (last_ff) begin
                  lanes_in.c = src.c ^ {56'd0, wide_ff ? siphash_pkg::TWEAK_WIDE :
                                                         siphash_pkg::TWEAK_NARROW};
                  cnt_in     = fin_rounds_ff;
               end
            end
         end
         siphash_pkg::ST_FIN1, siphash_pkg::ST_FIN2: begin
            if (!finishing) begin
               lanes_in = round_res;
               cnt_in   = cnt_ff - 4'd1;
            end else if (out_free) begin
               // Hold here while the digest register is full
               lanes_in     = src;
               out_valid_in = 1'b1;
               out_hash_in  = src.a ^ src.b ^ src.c ^ src.d;
               out_final_in = (state_ff == siphash_pkg::ST_FIN2) || !wide_ff;
               if (state_ff == siphash_pkg::ST_FIN1 && wide_ff) begin
                  lanes_in.b = src.b ^ {56'd0, siphash_pkg::TWEAK_SECOND};
                  cnt_in     = fin_rounds_ff;
               end
            end
         end
         default: begin
            lanes_in = lanes_ff;
         end
      endcase
   end

   assign req_stream.ready      = (state_ff == siphash_pkg::ST_IDLE);
   assign rsp_stream.valid      = out_valid_ff;
   assign rsp_stream.hash_word  = out_hash_ff;
   assign rsp_stream.final_part = out_final_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= siphash_pkg::ST_IDLE;
         in_msg_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         need_blk_ff  <= 1'b0;
         last_ff      <= 1'b0;
         cnt_ff       <= 4'd0;
         len_ff       <= 8'd0;
      end else begin
         state_ff     <= state_in;
         in_msg_ff    <= in_msg_in;
         out_valid_ff <= out_valid_in;
         need_blk_ff  <= need_blk_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lanes_ff     <= lanes_in;
      m_ff         <= m_in;
      blk_ff       <= blk_in;
      out_hash_ff  <= out_hash_in;
      out_final_ff <= out_final_in;
   end

   // CSR write port; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= 64'd0;
         key_high_ff    <= 64'd0;
         wide_ff        <= 1'b0;
         comp_rounds_ff <= siphash_pkg::RESET_C_ROUNDS;
         fin_rounds_ff  <= siphash_pkg::RESET_D_ROUNDS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            siphash_pkg::CSR_KEY_LOW:      key_low_ff     <= csr_write_data;
            siphash_pkg::CSR_KEY_HIGH:     key_high_ff    <= csr_write_data;
            siphash_pkg::CSR_WIDE_OUTPUT:  wide_ff        <= csr_write_data[0];
            siphash_pkg::CSR_COMP_ROUNDS:  comp_rounds_ff <= csr_write_data[3:0];
            siphash_pkg::CSR_FINAL_ROUNDS: fin_rounds_ff  <= csr_write_data[3:0];
            default: begin
               key_low_ff <= key_low_ff;
            end
         endcase
      end
   end

endmodule

// ===== rtl/siphash_round.sv =====
// One SipRound over the four lanes, the shared arithmetic unit of the sequencer.
`timescale 1ns / 1ps
module siphash_round (
   input  siphash_pkg::lanes_type round_src,
   output siphash_pkg::lanes_type round_res
);

   function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
      rotl = (x << s) | (x >> (64 - s));
   endfunction

   logic [63:0] a1, a2, a3, b1, b2, c1, c2, d1, d2;

   always_comb begin
      a1 = round_src.a + round_src.b;
      b1 = rotl(round_src.b, 13) ^ a1;
      a2 = rotl(a1, 32);
      c1 = round_src.c + round_src.d;
      d1 = rotl(round_src.d, 16) ^ c1;
      a3 = a2 + d1;
      d2 = rotl(d1, 21) ^ a3;
      c2 = c1 + b1;
      b2 = rotl(b1, 17) ^ c2;
      round_res.a = a3;
      round_res.b = b2;
      round_res.c = rotl(c2, 32);
      round_res.d = d2;
   end

endmodule

// ===== rtl/siphash_keyed_hash_unit_checker.sv =====
// Port-level checker for the SipHash unit, with its bind statement.
`timescale 1ns / 1ps
`include "siphash_keyed_hash_unit_assert.svh"
module siphash_keyed_hash_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_word,
   input logic        rsp_final_part
);

   // A stalled digest beat holds
   `SIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hash_word) && $stable(rsp_final_part))
   // The sequencer is busy right after it takes a beat
   `SIP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // No digest can appear in the cycle right after a beat is taken
   `SIP_ASSERT_NEXT(a_no_instant_digest, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid)
   // A non-final digest beat is followed only by more work, never an idle accept
   `SIP_ASSERT_IMPLIES(a_partial_blocks_input, clock, reset, rsp_valid && !rsp_final_part, !req_ready)

endmodule

bind siphash_keyed_hash_unit siphash_keyed_hash_unit_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_stream.valid),
   .req_ready      (req_stream.ready),
   .rsp_valid      (rsp_stream.valid),
   .rsp_ready      (rsp_stream.ready),
   .rsp_hash_word  (rsp_stream.hash_word),
   .rsp_final_part (rsp_stream.final_part)
);
